// ===== rtl/smpg_pkg.sv =====
// Shared types, constants and helpers for the sphere mesh point generator.
`default_nettype none
package smpg_pkg;

  localparam int MAX_DIV_DEF   = 255;
  localparam int TRIG_BITS_DEF = 16;

  localparam int RADIUS_W = 16;
  localparam int DIV_CFG_W = 8;
  localparam int GRID_W   = 8;
  localparam int POS_W    = 17;
  localparam int NORM_W   = 16;
  localparam int VIDX_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;

  localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 16'd256;
  localparam logic [DIV_CFG_W-1:0] COLUMNS_RST = 8'd16;
  localparam logic [DIV_CFG_W-1:0] ROWS_RST    = 8'd16;

  // Q28 fixed point
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [28:0] ONE_Q28    = 29'h1000_0000;
  localparam logic [15:0] NORM_MAX   = 16'd32767;

  // Taylor series state handed from cell to cell
  typedef struct packed {
    logic [28:0]        ts;  // current sin term magnitude
    logic [28:0]        tc;  // current cos term magnitude
    logic signed [31:0] ss;  // running sin sum
    logic signed [31:0] cs;  // running cos sum
    logic [29:0]        t2;  // angle squared, Q28
    logic [1:0]         q;   // quadrant
  } trm_t;

  typedef struct packed {
    logic              pv;
    logic              cstart;
    logic [VIDX_W-1:0] vidx;
  } side_t;

  // factorial step of term n: (2n)(2n+1) for sin, (2n-1)(2n) for cos
  function automatic int term_div(input logic is_sin, input int n);
    int k;
    begin
      k = is_sin ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
      return k;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sphere_mesh_point_generator_unit.sv =====
// Top level of the UV-sphere mesh point generator.
// Usage: write radius (index 0, Q8.8), columns (1) and rows (2) on the cfg port
// while no item is in flight; unknown indexes are ignored. Then pulse start with
// a grid point (in_grid_col, in_grid_row). busy is always low: one item may be
// started in every cycle, back to back.
// Each item gives exactly one result, shown for one cycle with out_strobe high
// and taken at the edge after. The path runs through the row of division cells
// (one quotient bit per cell, TRIG_BITS + 1 cells), two angle stages, five Taylor
// cells of four stages each and a clamp stage, then one stage for the unit
// products and one for the output scaling.
// Throughput is one item per clock.
// Points beyond the grid give an all-zero result, point_valid low.
// The receiver cannot stall; results are dropped if not taken.
// Reset returns radius to 1.0, columns and rows to 16 and clears all strobes
// in flight.
`default_nettype none
module sphere_mesh_point_generator_unit #(
  parameter int MAX_DIV   = smpg_pkg::MAX_DIV_DEF,
  parameter int TRIG_BITS = smpg_pkg::TRIG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [smpg_pkg::GRID_W-1:0]     in_grid_col,
  input  wire logic [smpg_pkg::GRID_W-1:0]     in_grid_row,
  input  wire logic                            cfg_we,
  input  wire logic [smpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [smpg_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output logic                                 out_strobe,
  output logic signed [smpg_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [smpg_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [smpg_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [smpg_pkg::NORM_W-1:0]   out_norm_x,
  output logic signed [smpg_pkg::NORM_W-1:0]   out_norm_y,
  output logic signed [smpg_pkg::NORM_W-1:0]   out_norm_z,
  output logic [smpg_pkg::VIDX_W-1:0]          out_vertex_index,
  output logic                                 out_cell_start,
  output logic                                 out_point_valid
);
  import smpg_pkg::*;

  localparam int DIVW = $clog2(MAX_DIV + 1);
  localparam int DW   = DIVW + 2;
  localparam int LW   = TRIG_BITS + 1;
  localparam int LAT  = TRIG_BITS + 26;

  logic [RADIUS_W-1:0]  radius_r;
  logic [DIV_CFG_W-1:0] columns_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:  radius_r  <= cfg_wdata;
        CFG_COLUMNS: columns_r <= cfg_wdata[DIV_CFG_W-1:0];
        CFG_ROWS:    rows_r    <= cfg_wdata[DIV_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // effective division counts
  logic [DIVW-1:0] nc, nr;
  assign nc = (32'(columns_r) > MAX_DIV) ? DIVW'(MAX_DIV) : DIVW'(columns_r);
  assign nr = (32'(rows_r) > MAX_DIV) ? DIVW'(MAX_DIV) : DIVW'(rows_r);

  // az phase = (col*2^(TB+1) + nc) / (2nc); el phase = (row*2^(TB+1) + 2nr) / (4nr)
  logic [DW-1:0] d_az, d_el;
  assign d_az = DW'(nc) << 1;
  assign d_el = DW'(nr) << 2;

  logic [DW-1:0] rem_az [0:LW];
  logic [LW-1:0] low_az [0:LW];
  logic [LW-1:0] quo_az [0:LW];
  logic [DW-1:0] rem_el [0:LW];
  logic [LW-1:0] low_el [0:LW];
  logic [LW-1:0] quo_el [0:LW];

  assign rem_az[0] = DW'(in_grid_col);
  assign low_az[0] = LW'(nc);
  assign quo_az[0] = '0;
  assign rem_el[0] = DW'(in_grid_row);
  assign low_el[0] = LW'(nr) << 1;
  assign quo_el[0] = '0;

  for (genvar i = 0; i < LW; i++) begin : g_div
    smpg_div_cell #(.DW(DW), .LW(LW)) u_az (
      .clk   (clk),
      .rem_i (rem_az[i]), .low_i (low_az[i]), .quo_i (quo_az[i]), .div_i (d_az),
      .rem_o (rem_az[i+1]), .low_o (low_az[i+1]), .quo_o (quo_az[i+1])
    );
    smpg_div_cell #(.DW(DW), .LW(LW)) u_el (
      .clk   (clk),
      .rem_i (rem_el[i]), .low_i (low_el[i]), .quo_i (quo_el[i]), .div_i (d_el),
      .rem_o (rem_el[i+1]), .low_o (low_el[i+1]), .quo_o (quo_el[i+1])
    );
  end

  // zero divisions give angle zero
  logic [LW-1:0] ph_az, ph_el;
  assign ph_az = (nc == '0) ? '0 : quo_az[LW];
  assign ph_el = (nr == '0) ? '0 : quo_el[LW];

  logic signed [29:0] se, ce, sa, ca;

  smpg_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_el (
    .clk (clk), .phase_i (ph_el), .sin_o (se), .cos_o (ce)
  );
  smpg_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_az (
    .clk (clk), .phase_i (ph_az), .sin_o (sa), .cos_o (ca)
  );

  // unit products, rounded half away from zero
  logic [28:0] se_m, ca_m, sa_m;
  logic [57:0] px, pz;
  logic [28:0] mx, mz;
  logic signed [29:0] ux_r, uz_r, ce_r;

  assign se_m = se[29] ? 29'(-se) : se[28:0];
  assign ca_m = ca[29] ? 29'(-ca) : ca[28:0];
  assign sa_m = sa[29] ? 29'(-sa) : sa[28:0];
  assign px   = 58'(se_m) * 58'(ca_m) + (58'(1) << 27);
  assign pz   = 58'(se_m) * 58'(sa_m) + (58'(1) << 27);
  assign mx   = px[56:28];
  assign mz   = pz[56:28];

  always_ff @(posedge clk) begin
    ux_r <= (se[29] != ca[29]) ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    uz_r <= (se[29] != sa[29]) ? -$signed({1'b0, mz}) : $signed({1'b0, mz});
    ce_r <= ce;
  end

  // side info travels beside the datapath
  logic [LAT-1:0] vld_r;
  side_t          side_r [0:LAT-1];
  side_t          side_in;
  logic           pv_in;
  logic [VIDX_W-1:0] vprod;

  assign pv_in = ({1'b0, in_grid_col} <= 9'(nc)) && ({1'b0, in_grid_row} <= 9'(nr));
  assign vprod = VIDX_W'((VIDX_W'(nc) + VIDX_W'(1)) * VIDX_W'(in_grid_row))
               + VIDX_W'(in_grid_col);

  always_comb begin
    side_in.pv     = pv_in;
    side_in.cstart = pv_in && (9'(in_grid_col) < 9'(nc)) && (9'(in_grid_row) < 9'(nr));
    side_in.vidx   = pv_in ? vprod : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
  end

  // output scaling
  function automatic logic [POS_W-1:0] to_pos(input logic signed [29:0] u,
                                              input logic [RADIUS_W-1:0] r);
    logic [28:0] m;
    logic [45:0] p;
    logic [POS_W-1:0] v;
    begin
      m = u[29] ? 29'(-u) : u[28:0];
      p = 46'(r) * 46'(m) + (46'(1) << 27);
      v = p[44:28];
      return u[29] ? POS_W'(-v) : v;
    end
  endfunction

  function automatic logic [NORM_W-1:0] to_norm(input logic signed [29:0] u);
    logic [28:0] m;
    logic [29:0] s;
    logic [NORM_W-1:0] v;
    begin
      m = u[29] ? 29'(-u) : u[28:0];
      s = 30'(m) + 30'd4096;
      v = (s[29:13] > 17'(NORM_MAX)) ? NORM_MAX : s[28:13];
      return u[29] ? NORM_W'(-v) : v;
    end
  endfunction

  logic pv_o;
  assign pv_o = side_r[LAT-2].pv;

  always_ff @(posedge clk) begin
    out_pos_x  <= pv_o ? to_pos(ux_r, radius_r) : '0;
    out_pos_y  <= pv_o ? to_pos(ce_r, radius_r) : '0;
    out_pos_z  <= pv_o ? to_pos(uz_r, radius_r) : '0;
    out_norm_x <= pv_o ? to_norm(ux_r) : '0;
    out_norm_y <= pv_o ? to_norm(ce_r) : '0;
    out_norm_z <= pv_o ? to_norm(uz_r) : '0;
  end

  assign out_strobe       = vld_r[LAT-1];
  assign out_vertex_index = side_r[LAT-1].vidx;
  assign out_cell_start   = side_r[LAT-1].cstart;
  assign out_point_valid  = side_r[LAT-1].pv;
endmodule
`default_nettype wire

// ===== rtl/smpg_div_cell.sv =====
// One restoring-division step: one quotient bit per cell, registered.
`default_nettype none
module smpg_div_cell #(
  parameter int DW = 12,
  parameter int LW = 17
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [LW-1:0] low_i,
  input  wire logic [LW-1:0] quo_i,
  input  wire logic [DW-1:0] div_i,
  output logic      [DW-1:0] rem_o,
  output logic      [LW-1:0] low_o,
  output logic      [LW-1:0] quo_o
);
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  assign trial   = {rem_i, low_i[LW-1]};
  assign ge      = (trial >= {1'b0, div_i});
  assign rem_nxt = ge ? DW'(trial - {1'b0, div_i}) : DW'(trial);

  always_ff @(posedge clk) begin
    rem_o <= rem_nxt;
    low_o <= {low_i[LW-2:0], 1'b0};
    quo_o <= {quo_i[LW-2:0], ge};
  end
endmodule
`default_nettype wire

// ===== rtl/smpg_taylor_cell.sv =====
// One Taylor term pair for sin and cos: multiply, reciprocal divide, fix up and sum.
`default_nettype none
module smpg_taylor_cell #(
  parameter int TERM = 1
) (
  input  wire logic         clk,
  input  wire smpg_pkg::trm_t d_i,
  output smpg_pkg::trm_t    d_o
);
  import smpg_pkg::*;

  localparam int KS = term_div(1'b1, TERM);
  localparam int KC = term_div(1'b0, TERM);
  localparam int SHS = 31 + $clog2(KS);
  localparam int SHC = 31 + $clog2(KC);
  localparam logic [63:0] MS = (64'd1 << SHS) / KS;
  localparam logic [63:0] MC = (64'd1 << SHC) / KC;
  localparam logic [30:0] KS31 = 31'(KS);
  localparam logic [30:0] KC31 = 31'(KC);

  trm_t        a_r, b_r;
  logic [30:0] ps_r, pc_r, ps2_r, pc2_r, es_r, ec_r;
  logic [58:0] ps_prod, pc_prod;
  logic [62:0] es_prod, ec_prod;
  logic [30:0] rs, rc, esf, ecf;
  trm_t        o_nxt;

  assign ps_prod = 59'(a_r.ts) * 59'(a_r.t2);
  assign pc_prod = 59'(a_r.tc) * 59'(a_r.t2);

  always_ff @(posedge clk) begin
    a_r  <= d_i;
  end

  always_comb begin
    es_prod = 63'(ps_r) * 63'(MS[31:0]);
    ec_prod = 63'(pc_r) * 63'(MC[31:0]);
  end

  always_ff @(posedge clk) begin
    ps_r <= ps_prod[58:28];
    pc_r <= pc_prod[58:28];
    b_r  <= a_r;
  end

  always_ff @(posedge clk) begin
    ps2_r <= ps_r;
    pc2_r <= pc_r;
    es_r  <= 31'(es_prod >> SHS);
    ec_r  <= 31'(ec_prod >> SHC);
  end

  trm_t c_r;
  always_ff @(posedge clk) begin
    c_r <= b_r;
  end

  // estimate is low by at most one
  always_comb begin
    rs  = ps2_r - 31'(es_r * KS31);
    rc  = pc2_r - 31'(ec_r * KC31);
    esf = (rs >= KS31) ? es_r + 31'd1 : es_r;
    ecf = (rc >= KC31) ? ec_r + 31'd1 : ec_r;
    o_nxt    = c_r;
    o_nxt.ts = 29'(esf);
    o_nxt.tc = 29'(ecf);
    if ((TERM % 2) == 1) begin
      o_nxt.ss = c_r.ss - $signed({1'b0, esf});
      o_nxt.cs = c_r.cs - $signed({1'b0, ecf});
    end else begin
      o_nxt.ss = c_r.ss + $signed({1'b0, esf});
      o_nxt.cs = c_r.cs + $signed({1'b0, ecf});
    end
  end

  always_ff @(posedge clk) begin
    d_o <= o_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/smpg_trig.sv =====
// Pipelined sin/cos of a phase: angle scaling, chain of Taylor cells, clamp and quadrant.
`default_nettype none
module smpg_trig #(
  parameter int TRIG_BITS = smpg_pkg::TRIG_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic [TRIG_BITS:0] phase_i,
  output logic signed [29:0]      sin_o,
  output logic signed [29:0]      cos_o
);
  import smpg_pkg::*;

  localparam int PW = TRIG_BITS + 30;
  localparam int NTERM = 5;

  logic [TRIG_BITS-3:0] x;
  logic [PW-1:0]        tprod;
  logic [28:0]          t_r, t2s_r;
  logic [1:0]           q_r, q2_r;
  logic [57:0]          tsq;
  logic [29:0]          t2_r;
  logic [28:0]          sm, cm;
  logic signed [29:0]   s_nxt, c_nxt;

  assign x     = phase_i[TRIG_BITS-3:0];
  assign tprod = PW'(x) * PW'(TWO_PI_Q28) + (PW'(1) << (TRIG_BITS - 1));

  always_ff @(posedge clk) begin
    t_r <= tprod[TRIG_BITS+28:TRIG_BITS];
    q_r <= phase_i[TRIG_BITS-1:TRIG_BITS-2];
  end

  assign tsq = 58'(t_r) * 58'(t_r);

  always_ff @(posedge clk) begin
    t2s_r <= t_r;
    q2_r  <= q_r;
    t2_r  <= tsq[57:28];
  end

  trm_t head;
  always_comb begin
    head.ts = t2s_r;
    head.tc = ONE_Q28;
    head.ss = $signed({3'b0, t2s_r});
    head.cs = $signed({3'b0, ONE_Q28});
    head.t2 = t2_r;
    head.q  = q2_r;
  end

  trm_t link [0:NTERM];
  assign link[0] = head;

  for (genvar i = 0; i < NTERM; i++) begin : g_term
    smpg_taylor_cell #(.TERM(i + 1)) u_cell (
      .clk (clk),
      .d_i (link[i]),
      .d_o (link[i+1])
    );
  end

  always_comb begin
    if (link[NTERM].ss < 0)                       sm = '0;
    else if (link[NTERM].ss > $signed({3'b0, ONE_Q28})) sm = ONE_Q28;
    else                                          sm = link[NTERM].ss[28:0];
    if (link[NTERM].cs < 0)                       cm = '0;
    else if (link[NTERM].cs > $signed({3'b0, ONE_Q28})) cm = ONE_Q28;
    else                                          cm = link[NTERM].cs[28:0];
    case (link[NTERM].q)
      2'd0: begin
        s_nxt = $signed({1'b0, sm});
        c_nxt = $signed({1'b0, cm});
      end
      2'd1: begin
        s_nxt = $signed({1'b0, cm});
        c_nxt = -$signed({1'b0, sm});
      end
      2'd2: begin
        s_nxt = -$signed({1'b0, sm});
        c_nxt = -$signed({1'b0, cm});
      end
      default: begin
        s_nxt = -$signed({1'b0, cm});
        c_nxt = $signed({1'b0, sm});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_o <= s_nxt;
    cos_o <= c_nxt;
  end
endmodule
`default_nettype wire
